### src/maap_pkg.sv
// maap_pkg: shared types and constants for the moving average altitude block
// used by every module under src except maap_ram; depends on nothing

package maap_pkg;

    // field widths fixed by the item format
    localparam int DATA_W   = 12;                  // sample, average, altitude
    localparam int DIVD_W   = 19;                  // 4095 * 100 fits in 19 bits
    localparam int DIVR_W   = 12;                  // span register
    localparam int CNT_W    = $clog2(DIVD_W);      // divider iteration count
    localparam int MUL_W    = 7;

    localparam logic [DATA_W-1:0] SPAN_RESET   = 12'd1241;
    localparam logic [MUL_W-1:0]  PERCENT_FULL = 7'd100;
    localparam logic [DATA_W-1:0] ALT_MAX      = 12'h7FF;  // +2047
    localparam logic [DATA_W-1:0] ALT_MIN      = 12'h800;  // -2048

    // func codes carried in tuser
    localparam logic FUNC_PUSH  = 1'b0;
    localparam logic FUNC_CALIB = 1'b1;

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b000_0001,
        ST_READ     = 7'b000_0010,
        ST_AVG      = 7'b000_0100,
        ST_MUL      = 7'b000_1000,
        ST_ALT_GO   = 7'b001_0000,
        ST_ALT_WAIT = 7'b010_0000,
        ST_DONE     = 7'b100_0000
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load_in;      // capture func and sample, read ring slot
        logic update;       // replace oldest sample, adjust window sum
        logic div_start;    // start the divider on scaled diff / span
        logic latch_avg;    // capture sum / depth as average (and land ref on calibrate)
        logic mul;          // form |avg - land| * 100 and its sign
        logic load_out;     // load result into output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic func;         // latched func of the item at work
        logic div_done;     // divider holds a finished quotient
    } t_stat;

endpackage

### src/maap_ram.sv
// maap_ram: generic single write port, single read port RAM with registered read
// no package dependency

module maap_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 20
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/maap_div.sv
// maap_div: restoring unsigned divider, one quotient bit per cycle
// depends on maap_pkg for widths

module maap_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [maap_pkg::DIVD_W-1:0] i_dividend,
    input  logic [maap_pkg::DIVR_W-1:0] i_divisor,
    output logic                        o_done,
    output logic [maap_pkg::DIVD_W-1:0] o_quot
);

    import maap_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIVR_W-1:0] r_rem;
    logic [DIVD_W-1:0] r_quo;
    logic [DIVR_W-1:0] r_dvs;

    logic [DIVR_W:0]   rem_sh;
    logic [DIVR_W:0]   rem_sub;
    logic              ge;

    always_comb begin
        rem_sh  = {r_rem, r_quo[DIVD_W-1]};
        rem_sub = rem_sh - {1'b0, r_dvs};
        ge      = (rem_sh >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(DIVD_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? rem_sub[DIVR_W-1:0] : rem_sh[DIVR_W-1:0];
            r_quo <= {r_quo[DIVD_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

### src/maap_ctrl.sv
// maap_ctrl: sequencing state machine for one item at a time
// depends on maap_pkg for state, command and status types

module maap_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    input  maap_pkg::t_stat i_stat,
    output maap_pkg::t_cmd  o_cmd
);

    import maap_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_m_tvalid;
    logic   n_m_tvalid;
    logic   out_free;

    assign out_free = !r_m_tvalid || m_tready;

    always_comb begin
        n_state    = r_state;
        n_m_tvalid = r_m_tvalid;
        o_cmd      = '0;
        if (r_m_tvalid && m_tready) begin
            n_m_tvalid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (s_tvalid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.update = (i_stat.func == FUNC_PUSH);
                n_state      = ST_AVG;
            end
            ST_AVG: begin
                o_cmd.latch_avg = 1'b1;
                n_state         = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_ALT_GO;
            end
            ST_ALT_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_ALT_WAIT;
            end
            ST_ALT_WAIT: begin
                if (i_stat.div_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_m_tvalid     = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_m_tvalid <= n_m_tvalid;
        end
    end

    assign s_tready = (r_state == ST_IDLE);
    assign m_tvalid = r_m_tvalid;

endmodule

### src/maap_dp.sv
// maap_dp: sample ring, window sum, land reference, span register, divider, result
// depends on maap_pkg, maap_ram and maap_div

module maap_dp #(
    parameter int DEPTH = 20
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  maap_pkg::t_cmd              i_cmd,
    output maap_pkg::t_stat             o_stat,
    input  logic                        i_func,
    input  logic [maap_pkg::DATA_W-1:0] i_sample,
    input  logic                        i_cfg_valid,
    input  logic [maap_pkg::DATA_W-1:0] i_cfg_data,
    output logic [maap_pkg::DATA_W-1:0] o_altitude_percent,
    output logic [maap_pkg::DATA_W-1:0] o_average_level
);

    import maap_pkg::*;

    localparam int AW  = $clog2(DEPTH);
    localparam int SW  = DATA_W + $clog2(DEPTH);
    // sum / depth as a reciprocal multiply, exact for every sum below 2**SW
    localparam int RSH = SW + AW;
    localparam int RW  = SW + 1;
    localparam int PW  = 2 * SW + 1;
    localparam logic [RW-1:0] RECIP =
        RW'(((64'd1 << RSH) + 64'(DEPTH) - 64'd1) / 64'(DEPTH));

    // control state
    logic [AW-1:0]     r_slot;
    logic [DEPTH-1:0]  r_valid;
    logic [SW-1:0]     r_sum;
    logic [DATA_W-1:0] r_land;
    logic [DATA_W-1:0] r_span;

    // payload
    logic              r_func;
    logic [DATA_W-1:0] r_sample;
    logic              r_old_vld;
    logic [DATA_W-1:0] r_avg;
    logic [DIVD_W-1:0] r_prod;
    logic              r_neg;
    logic [DATA_W-1:0] r_alt_out;
    logic [DATA_W-1:0] r_avg_out;

    logic [DATA_W-1:0] ram_rdata;
    logic [DATA_W-1:0] old_sample;
    logic [PW-1:0]     avg_prod;
    logic [DATA_W-1:0] avg_q;
    logic [DATA_W:0]   diff;
    logic [DATA_W-1:0] diff_abs;
    logic [DIVR_W-1:0] span_eff;
    logic [DIVD_W-1:0] div_quot;
    logic              div_done;
    logic [DATA_W-1:0] alt_val;

    maap_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (i_cmd.update),
        .i_waddr (r_slot),
        .i_wdata (r_sample),
        .i_re    (i_cmd.load_in),
        .i_raddr (r_slot),
        .o_rdata (ram_rdata)
    );

    // never-written slots read as zero
    assign old_sample = r_old_vld ? ram_rdata : '0;

    // window average, truncated
    assign avg_prod = PW'(r_sum) * PW'(RECIP);
    assign avg_q    = avg_prod[RSH +: DATA_W];

    assign span_eff = (r_span == '0) ? DIVR_W'(1) : r_span;

    maap_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_prod),
        .i_divisor  (span_eff),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_comb begin
        diff     = {1'b0, r_avg} - {1'b0, r_land};
        diff_abs = diff[DATA_W] ? DATA_W'(-diff) : diff[DATA_W-1:0];
    end

    // give the quotient its sign, negated when avg >= land, saturating to 12-bit two's complement
    always_comb begin
        if (r_neg) begin
            alt_val = (div_quot > DIVD_W'(ALT_MAX)) ? ALT_MAX : div_quot[DATA_W-1:0];
        end else begin
            alt_val = (div_quot > DIVD_W'(ALT_MIN)) ? ALT_MIN
                                                    : (~div_quot[DATA_W-1:0]) + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= '0;
            r_valid <= '0;
            r_sum   <= '0;
            r_land  <= '0;
            r_span  <= SPAN_RESET;
        end else begin
            if (i_cfg_valid) begin
                r_span <= i_cfg_data;
            end
            if (i_cmd.update) begin
                r_sum           <= r_sum - SW'(old_sample) + SW'(r_sample);
                r_valid[r_slot] <= 1'b1;
                r_slot          <= (r_slot == AW'(DEPTH - 1)) ? '0 : r_slot + 1'b1;
            end
            if (i_cmd.latch_avg && r_func == FUNC_CALIB) begin
                r_land <= avg_q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_func    <= i_func;
            r_sample  <= i_sample;
            r_old_vld <= r_valid[r_slot];
        end
        if (i_cmd.latch_avg) begin
            r_avg <= avg_q;
        end
        if (i_cmd.mul) begin
            r_prod <= DIVD_W'(diff_abs) * DIVD_W'(PERCENT_FULL);
            r_neg  <= diff[DATA_W];
        end
        if (i_cmd.load_out) begin
            r_alt_out <= alt_val;
            r_avg_out <= r_avg;
        end
    end

    assign o_stat.func     = r_func;
    assign o_stat.div_done = div_done;

    assign o_altitude_percent = r_alt_out;
    assign o_average_level    = r_avg_out;

endmodule

### src/moving_average_altitude_percent.sv
// moving_average_altitude_percent: top level, boxcar average of ADC samples with
// altitude as a percentage of span; depends on maap_pkg, maap_ctrl and maap_dp
//
// usage
// - input stream: s_tuser = func (0 push sample, 1 calibrate), s_tdata[11:0] = sample;
//   a calibrate transfer latches the current window average as land reference
//   and its sample is ignored
// - output stream: one transfer per input transfer, m_tdata[11:0] = altitude
//   percent (two's complement, saturated), m_tdata[23:12] = window average
// - config: i_cfg_valid/i_cfg_data write the span register (counts for one
//   hundred percent, 0 acts as 1); o_cfg_ready is always high; write only while idle
// - one item at a time: s_tready is high only while no item is at work; the ring
//   read, the ring update, the reciprocal multiply for sum / DEPTH and the scaling
//   multiply are done in turn, then the one-bit-per-cycle divider forms the scaled
//   difference / span, and once the result is loaded m_tvalid rises and the next
//   input transfer can follow
// - the output register holds a finished result while the receiver stalls, and
//   the next input is taken meanwhile; its result waits until that one is taken,
//   with s_tready low in the meantime
// - reset (i_rst_n low, synchronous) empties the ring (reads as zeros through
//   per-slot valid bits, no clearing pass), zeroes sum and land reference and
//   sets span to 1241; the first averages include those zeros

module moving_average_altitude_percent #(
    parameter int DEPTH = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] sample, [15:12] zero
    input  logic        s_tuser,   // [0] func
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [11:0] altitude_percent, [23:12] average_level
    // span register write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [11:0] i_cfg_data
);

    import maap_pkg::*;

    t_cmd              cmd;
    t_stat             stat;
    logic [DATA_W-1:0] altitude_percent;
    logic [DATA_W-1:0] average_level;

    // sequencing: idle, ring read, ring update, average multiply, scaling
    // multiply, altitude divide, output load
    maap_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .i_stat   (stat),
        .o_cmd    (cmd)
    );

    maap_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .i_func             (s_tuser),
        .i_sample           (s_tdata[DATA_W-1:0]),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_data         (i_cfg_data),
        .o_altitude_percent (altitude_percent),
        .o_average_level    (average_level)
    );

    // span writes are always taken
    assign o_cfg_ready = 1'b1;

    assign m_tdata = {average_level, altitude_percent};

endmodule
